// ===== hw/rtl/integer_text_formatter_core_macros.svh =====
// Assertion helpers for the formatter core RTL.
`ifndef INTEGER_TEXT_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TEXT_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ITF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ITF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/itf_pkg.sv =====
`default_nettype none

package itf_pkg;

  // Sequencer states of the formatter.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SIZE,
    ST_BOUND,
    ST_EMIT
  } state_t;

  // Radix codes as they arrive on the input.
  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // Digit register: 22 slots of 4 bits cover 22 octal, 20 decimal or 16 hex digits.
  localparam int DIG_SLOTS = 22;
  localparam int DIG_BITS  = 4 * DIG_SLOTS;
  localparam int CNT_W     = 7;

  // ASCII codes.
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_CASE    = 8'h20;

  // One digit value to its ASCII character; letters only occur in hex.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = (CH_UPPER_A + {4'd0, d} - 8'd10) | (lower ? CH_CASE : 8'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/integer_text_formatter_core.sv =====
// Formats one 64-bit integer as printf-style ASCII text, one character per output
// transfer, with out_tlast on the final character. An item is taken in from ST_IDLE;
// then, for decimal, ST_CONV runs shift-and-add-3 conversion (one magnitude bit
// per cycle); for octal and hex, none. Then ST_NORM finds the leading digit (up to
// 21 leading zero digits are stripped, one digit per cycle), ST_SIZE and ST_BOUND
// size the padding fields, and ST_EMIT sends the characters (1 to 63 characters)
// while the output is not stalled. A new item is taken once the last character of
// the previous one sits in the output register.
`default_nettype none
`include "integer_text_formatter_core_macros.svh"

module integer_text_formatter_core import itf_pkg::*; #(
  parameter int MAX_WIDTH  = 63,
  parameter int MAX_DIGITS = 60
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // value[63:0], radix_select[65:64], signed_mode[66], force_plus[67],
  // space_sign[68], alt_prefix[69], zero_pad[70], left_justify[71],
  // lower_case[72], min_width[78:73], min_digits[84:79]; bits [87:85] are unused
  input  wire logic [87:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_char[7:0]
  output logic [7:0]       out_tdata,
  // last_char
  output logic             out_tlast
);

  localparam logic [5:0] WIDTH_CAP = 6'(MAX_WIDTH);
  localparam logic [5:0] DIGIT_CAP = 6'(MAX_DIGITS);

  state_t state_r, state_nxt;

  logic [63:0]         mag_r, mag_nxt;
  logic [DIG_BITS-1:0] dig_r, dig_nxt;
  logic [5:0]          bitcnt_r, bitcnt_nxt;
  logic [4:0]          ndig_r, ndig_nxt;
  logic                lower_r, lower_nxt;
  logic                left_r, left_nxt;
  logic                zpad_r, zpad_nxt;
  logic                sign_len_r, sign_len_nxt;
  logic [7:0]          sign_char_r, sign_char_nxt;
  logic [1:0]          pfx_len_r, pfx_len_nxt;
  logic [5:0]          width_r, width_nxt;
  logic [5:0]          mind_r, mind_nxt;
  logic [5:0]          prec_r, prec_nxt;
  logic [5:0]          pad_r, pad_nxt;
  logic [CNT_W-1:0]    b1_r, b2_r, b3_r, b4_r, b5_r, total_r;
  logic [CNT_W-1:0]    b1_nxt, b2_nxt, b3_nxt, b4_nxt, b5_nxt, total_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [7:0]          out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Input field views.
  logic [63:0] in_value;
  logic [1:0]  in_radix;
  logic        in_signed, in_plus, in_space, in_alt, in_zpad, in_left, in_lower;
  logic [5:0]  in_width, in_mind;

  assign in_value  = in_tdata[63:0];
  assign in_radix  = in_tdata[65:64];
  assign in_signed = in_tdata[66];
  assign in_plus   = in_tdata[67];
  assign in_space  = in_tdata[68];
  assign in_alt    = in_tdata[69];
  assign in_zpad   = in_tdata[70];
  assign in_left   = in_tdata[71];
  assign in_lower  = in_tdata[72];
  assign in_width  = in_tdata[78:73];
  assign in_mind   = in_tdata[84:79];

  // Control decode.
  logic in_xfer, emit_adv, emit_last, conv_done, norm_done;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_radix == RADIX_DEC) ? ST_CONV : ST_NORM;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE:  state_nxt = ST_BOUND;
      ST_BOUND: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_adv && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    emit_adv  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EMIT: emit_adv  = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        emit_adv  = 1'b0;
      end
    endcase
  end

  assign in_xfer   = in_tvalid && in_tready;
  assign conv_done = (bitcnt_r == 6'd63);
  assign norm_done = (ndig_r == 5'd1) || (dig_r[DIG_BITS-1 -: 4] != 4'd0);
  assign emit_last = (pos_r == total_r - 7'd1);

  // Item load values.
  logic [1:0]          ld_radix;
  logic                ld_neg;
  logic [63:0]         ld_mag;
  logic [65:0]         ld_mag_ext;
  logic [DIG_BITS-1:0] hex_img, oct_img;

  always_comb begin
    ld_radix   = (in_radix == 2'd3) ? RADIX_HEX : in_radix;
    ld_neg     = in_signed && in_value[63];
    ld_mag     = ld_neg ? (64'd0 - in_value) : in_value;
    ld_mag_ext = {2'b00, ld_mag};
    hex_img    = {{(DIG_BITS-64){1'b0}}, ld_mag};
    for (int i = 0; i < DIG_SLOTS; i++) begin
      oct_img[4*i +: 4] = {1'b0, ld_mag_ext[3*i +: 3]};
    end
  end

  // Add-3 correction of every BCD slot before the next shift.
  logic [DIG_BITS-1:0] dab_adj;

  always_comb begin
    for (int i = 0; i < DIG_SLOTS; i++) begin
      dab_adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? (dig_r[4*i +: 4] + 4'd3)
                                                       : dig_r[4*i +: 4];
    end
  end

  // Sizing arithmetic on narrow counts.
  logic [5:0]       size_prec;
  logic [CNT_W-1:0] size_fixed;
  logic [CNT_W-1:0] bd_lead, bd_zeros, bd_trail;

  always_comb begin
    size_prec  = (mind_r > {1'b0, ndig_r}) ? mind_r : {1'b0, ndig_r};
    size_fixed = {6'd0, sign_len_r} + {5'd0, pfx_len_r} + {1'b0, size_prec};
    bd_lead    = (!left_r && !zpad_r) ? {1'b0, pad_r} : 7'd0;
    bd_trail   = left_r ? {1'b0, pad_r} : 7'd0;
    bd_zeros   = (zpad_r ? {1'b0, pad_r} : 7'd0) + {1'b0, prec_r} - {2'd0, ndig_r};
  end

  // Character at the current output position.
  logic [7:0] emit_char;
  logic       emit_digit;

  always_comb begin
    emit_digit = 1'b0;
    if (pos_r < b1_r) begin
      emit_char = CH_SPACE;
    end else if (pos_r < b2_r) begin
      emit_char = sign_char_r;
    end else if (pos_r < b3_r) begin
      emit_char = (pos_r == b2_r) ? CH_ZERO : (CH_UPPER_X | (lower_r ? CH_CASE : 8'd0));
    end else if (pos_r < b4_r) begin
      emit_char = CH_ZERO;
    end else if (pos_r < b5_r) begin
      emit_char  = digit_char(dig_r[DIG_BITS-1 -: 4], lower_r);
      emit_digit = 1'b1;
    end else begin
      emit_char = CH_SPACE;
    end
  end

  // Datapath next values.
  always_comb begin
    mag_nxt       = mag_r;
    dig_nxt       = dig_r;
    bitcnt_nxt    = bitcnt_r;
    ndig_nxt      = ndig_r;
    lower_nxt     = lower_r;
    left_nxt      = left_r;
    zpad_nxt      = zpad_r;
    sign_len_nxt  = sign_len_r;
    sign_char_nxt = sign_char_r;
    pfx_len_nxt   = pfx_len_r;
    width_nxt     = width_r;
    mind_nxt      = mind_r;
    prec_nxt      = prec_r;
    pad_nxt       = pad_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    b3_nxt        = b3_r;
    b4_nxt        = b4_r;
    b5_nxt        = b5_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;

    // The output register empties on a transfer unless refilled below.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          mag_nxt       = ld_mag;
          bitcnt_nxt    = 6'd0;
          ndig_nxt      = 5'(DIG_SLOTS);
          lower_nxt     = in_lower;
          left_nxt      = in_left;
          zpad_nxt      = in_zpad && !in_left;
          sign_len_nxt  = in_signed && (ld_neg || in_plus || in_space);
          sign_char_nxt = ld_neg ? CH_MINUS : (in_plus ? CH_PLUS : CH_SPACE);
          pfx_len_nxt   = !in_alt ? 2'd0 :
                          (ld_radix == RADIX_HEX) ? 2'd2 :
                          ((ld_radix == RADIX_OCT) && (in_value != 64'd0)) ? 2'd1 : 2'd0;
          width_nxt     = (in_width > WIDTH_CAP) ? WIDTH_CAP : in_width;
          mind_nxt      = (in_mind > DIGIT_CAP) ? DIGIT_CAP : in_mind;
          case (ld_radix)
            RADIX_OCT: dig_nxt = oct_img;
            RADIX_HEX: dig_nxt = hex_img;
            default:   dig_nxt = '0;
          endcase
        end
      end
      ST_CONV: begin
        // One magnitude bit enters the BCD register per cycle.
        dig_nxt    = {dab_adj[DIG_BITS-2:0], mag_r[63]};
        mag_nxt    = {mag_r[62:0], 1'b0};
        bitcnt_nxt = bitcnt_r + 6'd1;
      end
      ST_NORM: begin
        // Drop one leading zero digit per cycle, keeping at least one digit.
        if (!norm_done) begin
          dig_nxt  = {dig_r[DIG_BITS-5:0], 4'd0};
          ndig_nxt = ndig_r - 5'd1;
        end
      end
      ST_SIZE: begin
        prec_nxt = size_prec;
        pad_nxt  = ({1'b0, width_r} > size_fixed) ? 6'({1'b0, width_r} - size_fixed) : 6'd0;
      end
      ST_BOUND: begin
        b1_nxt    = bd_lead;
        b2_nxt    = bd_lead + {6'd0, sign_len_r};
        b3_nxt    = bd_lead + {6'd0, sign_len_r} + {5'd0, pfx_len_r};
        b4_nxt    = bd_lead + {6'd0, sign_len_r} + {5'd0, pfx_len_r} + bd_zeros;
        b5_nxt    = bd_lead + {6'd0, sign_len_r} + {5'd0, pfx_len_r} + bd_zeros
                    + {2'd0, ndig_r};
        total_nxt = bd_lead + {6'd0, sign_len_r} + {5'd0, pfx_len_r} + bd_zeros
                    + {2'd0, ndig_r} + bd_trail;
        pos_nxt   = 7'd0;
      end
      ST_EMIT: begin
        if (emit_adv) begin
          out_char_nxt  = emit_char;
          out_last_nxt  = emit_last;
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_r + 7'd1;
          if (emit_digit) begin
            dig_nxt = {dig_r[DIG_BITS-5:0], 4'd0};
          end
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  // Control registers take reset; the payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    dig_r       <= dig_nxt;
    bitcnt_r    <= bitcnt_nxt;
    ndig_r      <= ndig_nxt;
    lower_r     <= lower_nxt;
    left_r      <= left_nxt;
    zpad_r      <= zpad_nxt;
    sign_len_r  <= sign_len_nxt;
    sign_char_r <= sign_char_nxt;
    pfx_len_r   <= pfx_len_nxt;
    width_r     <= width_nxt;
    mind_r      <= mind_nxt;
    prec_r      <= prec_nxt;
    pad_r       <= pad_nxt;
    b1_r        <= b1_nxt;
    b2_r        <= b2_nxt;
    b3_r        <= b3_nxt;
    b4_r        <= b4_nxt;
    b5_r        <= b5_nxt;
    total_r     <= total_nxt;
    pos_r       <= pos_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // A transfer in starts conversion or digit stripping.
  `ITF_ASSERT_NEXT(a_load_next, clk, rst_n, in_xfer, (state_r == ST_CONV) || (state_r == ST_NORM), "input transfer did not start work")
  // At least one digit is always printed.
  `ITF_ASSERT_IMPLY(a_ndig_nonzero, clk, rst_n, state_r == ST_EMIT, ndig_r != 5'd0, "digit count is zero while emitting")
  // The output position stays inside the text.
  `ITF_ASSERT_IMPLY(a_pos_bound, clk, rst_n, state_r == ST_EMIT, pos_r < total_r, "output position beyond text length")
  // Loading the last character returns to idle with a marked character held.
  `ITF_ASSERT_NEXT(a_last_idle, clk, rst_n, emit_adv && emit_last, (state_r == ST_IDLE) && out_valid_r && out_last_r, "last character not followed by idle")

endmodule

`default_nettype wire
